[hdl/rpp_pkg.sv]
// rpp_pkg: shared constants and types for the reader progress percentile block
// no dependencies; used by reader_progress_percentile and the bench under verif
package rpp_pkg;

  localparam int USERS_DEF = 131072;
  localparam int PAGES_DEF = 1024;

  localparam int ID_W      = 17;  // user index field
  localparam int PC_W      = 11;  // page count field
  localparam int CNT_W     = 18;  // reach and active counters
  localparam int FRAC_BITS = 16;  // fractional bits of the answer
  localparam int FRAC_W    = FRAC_BITS + 1;

  localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(1) << FRAC_BITS;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_CHECK,
    ST_WALK,
    ST_WALK_END,
    ST_Q_READ,
    ST_Q_DIV
  } state_t;

endpackage

[hdl/rpp_ram.sv]
// rpp_ram: generic single-write, single-read ram with registered read data
// no dependencies
module rpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/rpp_div.sv]
// rpp_div: restoring unsigned divider, one quotient bit per cycle
// no package dependencies
module rpp_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             run_r, done_r;
  logic [CW-1:0]    cnt_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [NUM_W-1:0] q_r;

  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, q_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NUM_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      // remainder stays below the divisor
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      q_r   <= {q_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

[hdl/reader_progress_percentile.sv]
// reader_progress_percentile: per-user reading progress and percentile-rank answers
// depends on rpp_pkg, rpp_ram (progress and reach memories) and rpp_div
//
//  channel   ports                                         handshake
//  -------   --------------------------------------------  ----------------------------
//  request   in_kind, in_user_id, in_page_count             start high while busy low
//  result    out_cheer_fraction                             out_strobe, one cycle, no stall
//
// after reset a clearing pass zeroes both memories, one address a cycle, with busy held
// high until the pass ends
// an update reads the stored progress, checks it, walks each newly reached page, then
// drains the last reach write; the reach walk is one read-modify-write per cycle on
// the page ram; a query answers at the check if it needs no division, else after the
// one-bit-per-cycle divider over a 34-bit dividend
// one request is in work at a time; results cannot be held off by the receiver
module reader_progress_percentile #(
  parameter int USERS = rpp_pkg::USERS_DEF,
  parameter int PAGES = rpp_pkg::PAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_kind,
  input  logic [rpp_pkg::ID_W-1:0]   in_user_id,
  input  logic [rpp_pkg::PC_W-1:0]   in_page_count,
  output logic                       out_strobe,
  output logic [rpp_pkg::FRAC_W-1:0] out_cheer_fraction
);

  localparam int CNT_W = rpp_pkg::CNT_W;
  localparam int FRAC_W = rpp_pkg::FRAC_W;
  localparam int NUM_W = CNT_W + rpp_pkg::FRAC_BITS;
  localparam int UW    = (USERS > 1) ? $clog2(USERS) : 1;   // progress ram address
  localparam int PIW   = (PAGES > 1) ? $clog2(PAGES) : 1;   // reach ram address
  localparam int PW    = $clog2(PAGES + 1);                 // progress value 0..PAGES
  localparam int CLR_N = (USERS > PAGES) ? USERS : PAGES;
  localparam int CLW   = $clog2(CLR_N + 1);

  rpp_pkg::state_t state_r, state_nxt;

  // control registers
  logic [CLW-1:0]   clr_r, clr_nxt;
  logic [CNT_W-1:0] act_r, act_nxt;        // active user count
  logic             strobe_r, strobe_nxt;
  logic             pend_r, pend_nxt;      // reach write waiting for its read data

  // payload registers
  logic [PW-1:0]     idx_r, idx_nxt;       // next page to walk
  logic [PIW-1:0]    wa_r, wa_nxt;         // address of the pending reach write
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic              kind_r;
  logic [UW-1:0]     uid_r;
  logic [PW-1:0]     p_r;                  // saturated new progress
  logic              ok_r;                 // user index in range

  // memory ports
  logic             u_we, u_re;
  logic [UW-1:0]    u_waddr, u_raddr;
  logic [PW-1:0]    u_wdata, u_rdata;
  logic             r_we, r_re;
  logic [PIW-1:0]   r_waddr, r_raddr;
  logic [CNT_W-1:0] r_wdata, r_rdata;

  // divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [CNT_W-1:0] div_den;

  logic accept;

  // derived values
  logic [PW-1:0]    cur_m1, idx_inc;
  logic             adv, q_trivial;
  logic [CNT_W-1:0] num;

  assign busy   = (state_r != rpp_pkg::ST_IDLE);
  assign accept = start && !busy;

  rpp_ram #(.WIDTH(PW), .DEPTH(USERS)) u_progress_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .re    (u_re),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

  rpp_ram #(.WIDTH(CNT_W), .DEPTH(PAGES)) u_reach_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .re    (r_re),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  rpp_div #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    cur_m1    = u_rdata - PW'(1);
    idx_inc   = idx_r + PW'(1);
    // an update moves only when the user index is in range and the new total is above the stored one
    adv       = ok_r && (p_r > u_rdata);
    // queries answered without the reach count: unknown or inactive user, lone user
    q_trivial = !ok_r || (u_rdata == '0) || (act_r <= CNT_W'(1));
    // users with less progress; clamped to zero when a wrapped counter puts reach at or above it
    num       = (r_rdata >= act_r) ? '0 : (act_r - r_rdata);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpp_pkg::ST_CLEAR: begin
        if (clr_r == CLW'(CLR_N - 1)) begin
          state_nxt = rpp_pkg::ST_IDLE;
        end
      end
      rpp_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = rpp_pkg::ST_LOOK;
        end
      end
      rpp_pkg::ST_LOOK: state_nxt = rpp_pkg::ST_CHECK;
      rpp_pkg::ST_CHECK: begin
        if (kind_r == rpp_pkg::KIND_UPDATE) begin
          state_nxt = adv ? rpp_pkg::ST_WALK : rpp_pkg::ST_IDLE;
        end else begin
          state_nxt = q_trivial ? rpp_pkg::ST_IDLE : rpp_pkg::ST_Q_READ;
        end
      end
      rpp_pkg::ST_WALK: begin
        if (idx_inc == p_r) begin
          state_nxt = rpp_pkg::ST_WALK_END;
        end
      end
      rpp_pkg::ST_WALK_END: state_nxt = rpp_pkg::ST_IDLE;
      rpp_pkg::ST_Q_READ:   state_nxt = rpp_pkg::ST_Q_DIV;
      rpp_pkg::ST_Q_DIV: begin
        if (div_done) begin
          state_nxt = rpp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rpp_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    clr_nxt    = clr_r;
    act_nxt    = act_r;
    strobe_nxt = 1'b0;
    pend_nxt   = pend_r;
    idx_nxt    = idx_r;
    wa_nxt     = wa_r;
    frac_nxt   = frac_r;

    u_we    = 1'b0;
    u_waddr = uid_r;
    u_wdata = p_r;
    u_re    = 1'b0;
    u_raddr = uid_r;
    r_we    = 1'b0;
    r_waddr = wa_r;
    r_wdata = r_rdata + CNT_W'(1);
    r_re    = 1'b0;
    r_raddr = idx_r[PIW-1:0];

    div_start = 1'b0;
    div_num   = {num, rpp_pkg::FRAC_BITS'(0)};
    div_den   = act_r - CNT_W'(1);

    unique case (state_r)
      rpp_pkg::ST_CLEAR: begin
        // both memories swept together from address zero
        clr_nxt = clr_r + CLW'(1);
        if (clr_r < CLW'(USERS)) begin
          u_we    = 1'b1;
          u_waddr = clr_r[UW-1:0];
          u_wdata = '0;
        end
        if (clr_r < CLW'(PAGES)) begin
          r_we    = 1'b1;
          r_waddr = clr_r[PIW-1:0];
          r_wdata = '0;
        end
      end
      rpp_pkg::ST_IDLE: begin
      end
      rpp_pkg::ST_LOOK: begin
        u_re = 1'b1;
      end
      rpp_pkg::ST_CHECK: begin
        if (kind_r == rpp_pkg::KIND_UPDATE) begin
          if (adv) begin
            u_we     = 1'b1;
            idx_nxt  = u_rdata;
            pend_nxt = 1'b0;
            if (u_rdata == '0) begin
              act_nxt = act_r + CNT_W'(1);
            end
          end
        end else begin
          if (!ok_r || (u_rdata == '0)) begin
            strobe_nxt = 1'b1;
            frac_nxt   = '0;
          end else if (act_r <= CNT_W'(1)) begin
            strobe_nxt = 1'b1;
            frac_nxt   = rpp_pkg::ONE_Q16;
          end else begin
            r_re    = 1'b1;
            r_raddr = cur_m1[PIW-1:0];
          end
        end
      end
      rpp_pkg::ST_WALK: begin
        // read this page, write back the one read last cycle
        r_re     = 1'b1;
        r_we     = pend_r;
        pend_nxt = 1'b1;
        wa_nxt   = idx_r[PIW-1:0];
        idx_nxt  = idx_inc;
      end
      rpp_pkg::ST_WALK_END: begin
        r_we     = pend_r;
        pend_nxt = 1'b0;
      end
      rpp_pkg::ST_Q_READ: begin
        div_start = 1'b1;
      end
      rpp_pkg::ST_Q_DIV: begin
        if (div_done) begin
          strobe_nxt = 1'b1;
          frac_nxt   = (div_quo > NUM_W'(rpp_pkg::ONE_Q16)) ? rpp_pkg::ONE_Q16
                                                           : div_quo[FRAC_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rpp_pkg::ST_CLEAR;
      clr_r    <= '0;
      act_r    <= '0;
      strobe_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      act_r    <= act_nxt;
      strobe_r <= strobe_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    wa_r   <= wa_nxt;
    frac_r <= frac_nxt;
    if (accept) begin
      kind_r <= in_kind;
      uid_r  <= UW'(in_user_id);
      ok_r   <= 32'(in_user_id) < 32'(USERS);
      // totals beyond the book length saturate
      p_r    <= (32'(in_page_count) > 32'(PAGES)) ? PW'(PAGES) : PW'(in_page_count);
    end
  end

  assign out_strobe         = strobe_r;
  assign out_cheer_fraction = frac_r;

endmodule

[verif/reader_progress_percentile_tb.sv]
// reader_progress_percentile_tb: self-checking bench for the reader progress percentile block
// depends on rpp_pkg and reader_progress_percentile; predicts every cheer answer and
// compares it with the result strobe, directed corner requests first, then random traffic
module reader_progress_percentile_tb;

  // no acceptance or result in this many cycles means the block hung; the post-reset clearing
  // pass alone holds busy while it sweeps USERS_DEF addresses, so leave several times that
  localparam int HANG_LIMIT   = 4 * rpp_pkg::USERS_DEF;
  // cycles to let an update that has no result finish its page walk
  localparam int SETTLE_CYC   = rpp_pkg::PAGES_DEF + 200;
  localparam int POOL_SIZE    = 40;
  localparam int RANDOM_ITEMS = 1950;
  localparam int SHOW_MAX     = 10;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       in_kind = rpp_pkg::KIND_UPDATE;
  logic [rpp_pkg::ID_W-1:0]   in_user_id = '0;
  logic [rpp_pkg::PC_W-1:0]   in_page_count = '0;
  logic                       out_strobe;
  logic [rpp_pkg::FRAC_W-1:0] out_cheer_fraction;

  // shadow of the block's stores, all zero like the cleared memories
  bit [rpp_pkg::PC_W-1:0]  reader_pages [rpp_pkg::USERS_DEF];
  bit [rpp_pkg::CNT_W-1:0] readers_past_page [rpp_pkg::PAGES_DEF];
  bit [rpp_pkg::CNT_W-1:0] active_readers;

  // cheer answers still owed by the block, oldest first
  logic [rpp_pkg::FRAC_W-1:0] owed_fractions [$];
  int                         fail_count = 0;
  int                         quiet_cycles = 0;

  reader_progress_percentile dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_user_id        (in_user_id),
    .in_page_count     (in_page_count),
    .out_strobe        (out_strobe),
    .out_cheer_fraction(out_cheer_fraction)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // page count as the block stores it: anything past the last page clamps to it
  function automatic logic [rpp_pkg::PC_W-1:0] clamp_pages(
      input logic [rpp_pkg::PC_W-1:0] pc);
    return (pc > rpp_pkg::PAGES_DEF) ? rpp_pkg::PC_W'(rpp_pkg::PAGES_DEF) : pc;
  endfunction

  // reading update: bump the reach count of every page newly passed
  function automatic void note_progress(input logic [rpp_pkg::ID_W-1:0] uid,
                                        input logic [rpp_pkg::PC_W-1:0] pc);
    logic [rpp_pkg::PC_W-1:0] lim;
    logic [rpp_pkg::PC_W-1:0] cur;
    lim = clamp_pages(pc);
    cur = reader_pages[uid];
    // no growth, no change at all (covers page count 0 for a new reader)
    if (lim <= cur) return;
    if (cur == '0) active_readers = active_readers + 1'b1;
    for (int i = int'(cur); i < int'(lim); i++)
      readers_past_page[i] = readers_past_page[i] + 1'b1;
    reader_pages[uid] = lim;
  endfunction

  // cheer answer: share of the other active readers behind this one, Q1.16, truncated
  function automatic logic [rpp_pkg::FRAC_W-1:0] rank_of_reader(
      input logic [rpp_pkg::ID_W-1:0] uid);
    logic [rpp_pkg::PC_W-1:0]  p;
    logic [rpp_pkg::CNT_W-1:0] reach;
    longint unsigned           num;
    longint unsigned           den;
    longint unsigned           q;
    p = reader_pages[uid];
    // a reader who never read anything ranks nowhere
    if (p == '0 || p > rpp_pkg::PAGES_DEF) return '0;
    // alone (or a wrapped count): the reader leads by definition
    if (active_readers <= 1) return rpp_pkg::ONE_Q16;
    reach = readers_past_page[p - 1'b1];
    num = (reach >= active_readers) ? 64'd0 : 64'(active_readers - reach);
    den = 64'(active_readers - 1'b1);
    q = (num << rpp_pkg::FRAC_BITS) / den;
    if (q > 64'(rpp_pkg::ONE_Q16)) q = 64'(rpp_pkg::ONE_Q16);
    return q[rpp_pkg::FRAC_W-1:0];
  endfunction

  // does this request change anything or produce an answer
  function automatic bit has_effect(input logic kind, input logic [rpp_pkg::ID_W-1:0] uid,
                                    input logic [rpp_pkg::PC_W-1:0] pc);
    return kind == rpp_pkg::KIND_QUERY || clamp_pages(pc) > reader_pages[uid];
  endfunction

  // present one request and hold it until the block takes it; start stays high on
  // return so a back-to-back request needs no second assignment in the same step
  task automatic send_request(input logic kind, input logic [rpp_pkg::ID_W-1:0] uid,
                              input logic [rpp_pkg::PC_W-1:0] pc);
    start         <= 1'b1;
    in_kind       <= kind;
    in_user_id    <= uid;
    in_page_count <= pc;
    do @(posedge clk); while (busy);
    // taken at this edge: the shadow moves in request order
    if (kind == rpp_pkg::KIND_QUERY)
      owed_fractions.push_back(rank_of_reader(uid));
    else
      note_progress(uid, pc);
  endtask

  // drop start for the pause given by n, none if n is zero, and put junk on the fields meanwhile
  task automatic pause_sender(input int n);
    if (n == 0) return;
    start         <= 1'b0;
    in_kind       <= 1'($urandom);
    in_user_id    <= rpp_pkg::ID_W'($urandom);
    in_page_count <= rpp_pkg::PC_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 9);
    return $urandom_range(20, 60);
  endfunction

  // nothing read yet: every query answers zero, a zero-page update is a no-op
  task automatic test_empty_memory();
    send_request(rpp_pkg::KIND_QUERY, '0, '0);
    pause_sender(sender_gap());
    send_request(rpp_pkg::KIND_QUERY, '1, '1);
    send_request(rpp_pkg::KIND_UPDATE, rpp_pkg::ID_W'(5), '0);
    pause_sender(sender_gap());
    send_request(rpp_pkg::KIND_QUERY, rpp_pkg::ID_W'(5), '0);
  endtask

  // a single active reader always leads; updates that do not grow are dropped
  task automatic test_lone_reader();
    send_request(rpp_pkg::KIND_UPDATE, '1, rpp_pkg::PC_W'(1));
    send_request(rpp_pkg::KIND_QUERY, '1, '0);
    pause_sender(sender_gap());
    send_request(rpp_pkg::KIND_UPDATE, '1, rpp_pkg::PC_W'(1));
    send_request(rpp_pkg::KIND_UPDATE, '1, '0);
    send_request(rpp_pkg::KIND_QUERY, '1, '1);
  endtask

  // page counts at, below and past the last page, alternating bit patterns on both fields
  task automatic test_page_limits();
    send_request(rpp_pkg::KIND_UPDATE, '0, '1);
    pause_sender(sender_gap());
    send_request(rpp_pkg::KIND_QUERY, '0, '0);
    send_request(rpp_pkg::KIND_QUERY, '1, '0);
    send_request(rpp_pkg::KIND_UPDATE, rpp_pkg::ID_W'('h15555), rpp_pkg::PC_W'('h555));
    send_request(rpp_pkg::KIND_UPDATE, rpp_pkg::ID_W'('h0AAAA), rpp_pkg::PC_W'('h2AA));
    send_request(rpp_pkg::KIND_UPDATE, rpp_pkg::ID_W'(9),
                 rpp_pkg::PC_W'(rpp_pkg::PAGES_DEF));
    send_request(rpp_pkg::KIND_QUERY, rpp_pkg::ID_W'('h15555), '0);
    send_request(rpp_pkg::KIND_QUERY, rpp_pkg::ID_W'('h0AAAA), '0);
  endtask

  // equal progress counts as not behind; a reader with no pages read answers zero
  task automatic test_rank_ties();
    send_request(rpp_pkg::KIND_UPDATE, rpp_pkg::ID_W'(7),
                 rpp_pkg::PC_W'(rpp_pkg::PAGES_DEF - 1));
    send_request(rpp_pkg::KIND_UPDATE, rpp_pkg::ID_W'(7),
                 rpp_pkg::PC_W'(rpp_pkg::PAGES_DEF));
    pause_sender(sender_gap());
    send_request(rpp_pkg::KIND_QUERY, rpp_pkg::ID_W'(7), '0);
    send_request(rpp_pkg::KIND_QUERY, rpp_pkg::ID_W'(5), '0);
    send_request(rpp_pkg::KIND_QUERY, rpp_pkg::ID_W'(9), '0);
  endtask

  // random mix over a small reader pool so progress builds up and ranks spread;
  // updates mostly grow by a few pages, a few jump far or go nowhere
  task automatic test_random_traffic(input int goal);
    logic [rpp_pkg::ID_W-1:0] pool [POOL_SIZE];
    logic [rpp_pkg::ID_W-1:0] uid;
    logic [rpp_pkg::PC_W-1:0] pc;
    logic [rpp_pkg::PC_W-1:0] cur;
    logic                     kind;
    int                       taken;
    int                       burst_left;
    int                       r;
    taken = 0;
    burst_left = 0;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = rpp_pkg::ID_W'($urandom);
    while (taken < goal) begin
      uid  = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : rpp_pkg::ID_W'($urandom);
      kind = ($urandom_range(0, 1) == 0) ? rpp_pkg::KIND_UPDATE : rpp_pkg::KIND_QUERY;
      cur  = reader_pages[uid];
      r    = $urandom_range(0, 99);
      if (kind == rpp_pkg::KIND_QUERY)
        pc = rpp_pkg::PC_W'($urandom);
      else if (r < 8)
        pc = rpp_pkg::PC_W'($urandom_range(0, int'(cur)));
      else if (r < 11)
        pc = rpp_pkg::PC_W'($urandom_range(int'(cur) + 1, (1 << rpp_pkg::PC_W) - 1));
      else
        pc = cur + rpp_pkg::PC_W'($urandom_range(1, 6));
      if (has_effect(kind, uid, pc)) taken++;
      send_request(kind, uid, pc);
      // occasional stretch of back-to-back requests
      if (burst_left == 0 && $urandom_range(0, 99) == 0)
        burst_left = $urandom_range(20, 60);
      if (burst_left > 0)
        burst_left--;
      else
        pause_sender(sender_gap());
    end
  endtask

  // result checker: the receiver never stalls, so every strobe is taken
  always @(posedge clk) begin
    logic [rpp_pkg::FRAC_W-1:0] want;
    if (rst_n && out_strobe) begin
      if (owed_fractions.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_MAX)
          $display("unexpected cheer answer %0d with no query waiting", out_cheer_fraction);
      end else begin
        want = owed_fractions.pop_front();
        if (out_cheer_fraction !== want) begin
          fail_count++;
          if (fail_count <= SHOW_MAX)
            $display("cheer answer mismatch: expected %0d, got %0d", want,
                     out_cheer_fraction);
        end
      end
    end
  end

  // hang watchdog: any request or result taken resets it
  always @(posedge clk) begin
    if ((start && !busy && rst_n) || out_strobe)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_memory();
    test_lone_reader();
    test_page_limits();
    test_rank_ties();
    test_random_traffic(RANDOM_ITEMS);
    pause_sender(1);
    // all requests are in; collect the owed answers, then let a last walk drain
    while (owed_fractions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0 && owed_fractions.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
